[rtl/bounded_deque_with_search_macros.svh]
// Assertion macros used by the checking file of the deque.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDQS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bounded_deque_with_search: check failed");

// Next-cycle implication, disabled during reset.
`define BDQS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bounded_deque_with_search: check failed");

`endif

[rtl/bdqs_pkg.sv]
package bdqs_pkg;

   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_HEAD = 3'd0,
      ACT_PUSH_TAIL = 3'd1,
      ACT_POP_HEAD  = 3'd2,
      ACT_POP_TAIL  = 3'd3,
      ACT_FIND      = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   // Result handed from the controller to the output stage.
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       found;
   } res_flags_type;

endpackage

[rtl/bdqs_ram.sv]
module bdqs_ram #(
   parameter int DEPTH = 16,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [bdqs_pkg::VALUE_W-1:0] wr_data,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [bdqs_pkg::VALUE_W-1:0] rd_data
);
   import bdqs_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bdqs_ctrl.sv]
module bdqs_ctrl #(
   parameter int DEPTH = 16,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bdqs_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [bdqs_pkg::VALUE_W-1:0] req_value,
   input  logic                                out_free,
   output bdqs_pkg::res_flags_type             res_flags,
   output logic [CNT_W-1:0]                    res_count,
   output logic                                mem_we,
   output logic [IDX_W-1:0]                    mem_waddr,
   output logic [bdqs_pkg::VALUE_W-1:0]        mem_wdata,
   output logic [IDX_W-1:0]                    mem_raddr,
   input  logic [bdqs_pkg::VALUE_W-1:0]        mem_rdata
);
   import bdqs_pkg::*;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]   cmp_ff, cmp_in;
   res_flags_type      pend_ff, pend_in;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic [IDX_W-1:0]   head_dec;
   logic [IDX_W-1:0]   head_inc;
   logic [IDX_W-1:0]   tail_addr;
   logic [IDX_W-1:0]   cmp_next;
   logic               hit;
   logic               last;

   // Ring position of base + off, both below DEPTH, so one subtract suffices.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      cmp_ff <= cmp_in;
   end

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign head_dec  = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
   assign head_inc  = ring_add(head_ff, IDX_W'(1));
   assign tail_addr = ring_add(head_ff, count_ff[IDX_W-1:0]);
   assign cmp_next  = cmp_ff + IDX_W'(1);
   assign hit       = (mem_rdata == key_ff);
   assign last      = ((CNT_W'(cmp_ff) + CNT_W'(1)) == count_ff);

   // A held result may leave in the same cycle as a new item arrives.
   assign req_ready = (state_ff == ST_IDLE) && (!pend_ff.valid || out_free);
   assign accept    = req_valid && req_ready;
   assign res_flags = pend_ff;
   assign res_count = count_ff;
   assign mem_wdata = req_value;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      cmp_in    = cmp_ff;
      pend_in   = pend_ff;
      mem_we    = 1'b0;
      mem_waddr = head_dec;
      mem_raddr = head_ff;
      if (pend_ff.valid && out_free) begin
         pend_in.valid = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in.valid  = 1'b1;
               pend_in.status = STATUS_OK;
               pend_in.found  = 1'b0;
               case (req_action)
                  ACT_PUSH_HEAD: begin
                     if (is_full) begin
                        pend_in.status = STATUS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        head_in  = head_dec;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_PUSH_TAIL: begin
                     mem_waddr = tail_addr;
                     if (is_full) begin
                        pend_in.status = STATUS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP_HEAD: begin
                     if (is_empty) begin
                        pend_in.status = STATUS_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_POP_TAIL: begin
                     if (is_empty) begin
                        pend_in.status = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_FIND: begin
                     if (is_empty) begin
                        pend_in.status = STATUS_EMPTY;
                     end else begin
                        // The head entry is being read now; compare it next cycle.
                        pend_in.valid = 1'b0;
                        key_in        = req_value;
                        cmp_in        = '0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_raddr = ring_add(head_ff, cmp_next);
            if (hit || last) begin
               pend_in.valid  = 1'b1;
               pend_in.status = STATUS_OK;
               pend_in.found  = hit;
               state_in       = ST_IDLE;
            end else begin
               cmp_in = cmp_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/bounded_deque_with_search.sv]
// Bounded double-ended queue of DEPTH signed 32-bit values with a value search.
// Each request transfer carries one action (push at the head, push at the tail, pop from
// the head, pop from the tail, or find) and yields exactly one response transfer with a
// status (ok, empty or full), a found flag and the element count after the action.
// Pushes, pops and unused action codes may follow one another on every cycle while
// the response side keeps up. A find on a non-empty store walks the stored values from
// the head through the single read port of the entry memory, one value per cycle, and
// stops at the first match, having compared at most element-count values; no request is
// taken meanwhile. Values popped are discarded and never appear on the response. A
// response waiting for rsp_tready does not block the next request: the controller's
// one-entry result register takes the next result, and outside a find req_tready is
// low only when both it and the output register are occupied.
// The entry memory needs no clearing after reset; only written entries are ever compared.
module bounded_deque_with_search #(
   parameter int DEPTH = 16,
   localparam int CNT_W       = $clog2(DEPTH + 1),
   localparam int IDX_W       = $clog2(DEPTH),
   localparam int REQ_TDATA_W = ((bdqs_pkg::ACTION_W + bdqs_pkg::VALUE_W + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((bdqs_pkg::STATUS_W + 1 + CNT_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // From bit 0 up: action (3 bits), value (32 bits, signed), zero padding.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // From bit 0 up: status (2 bits), found (1 bit), element_count, zero padding.
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);
   import bdqs_pkg::*;

   logic [ACTION_W-1:0]       req_action;
   logic signed [VALUE_W-1:0] req_value;

   res_flags_type             res_flags;
   logic [CNT_W-1:0]          res_count;
   logic                      out_free;
   logic                      out_load;

   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic [VALUE_W-1:0]        mem_wdata;
   logic [IDX_W-1:0]          mem_raddr;
   logic [VALUE_W-1:0]        mem_rdata;

   // Output register: the response stage towards the consumer.
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic                      rsp_found_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   assign req_action = req_tdata[ACTION_W-1:0];
   assign req_value  = req_tdata[ACTION_W +: VALUE_W];

   // The output register can take a result when empty or when it is being emptied.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = res_flags.valid && out_free;

   bdqs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_action),
      .req_value  (req_value),
      .out_free   (out_free),
      .res_flags  (res_flags),
      .res_count  (res_count),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // A write never meets a read whose data is used: a search only reads, and pushes are
   // not taken while a search is in progress.
   bdqs_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= res_flags.status;
         rsp_found_ff  <= res_flags.found;
         rsp_count_ff  <= res_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                   = '0;
      rsp_tdata[STATUS_W-1:0]     = rsp_status_ff;
      rsp_tdata[STATUS_W]         = rsp_found_ff;
      rsp_tdata[STATUS_W+1 +: CNT_W] = rsp_count_ff;
   end

endmodule

[rtl/bdqs_checker.sv]
`include "bounded_deque_with_search_macros.svh"

module bdqs_checker #(
   parameter int DEPTH = 16,
   localparam int CNT_W       = $clog2(DEPTH + 1),
   localparam int RSP_TDATA_W = ((bdqs_pkg::STATUS_W + 1 + CNT_W + 7) / 8) * 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);
   import bdqs_pkg::*;

   logic [STATUS_W-1:0] status;
   logic                found;
   logic [CNT_W-1:0]    count;
   logic                rsp_stall;
   logic                rsp_full;
   logic                rsp_empty;

   assign status    = rsp_tdata[STATUS_W-1:0];
   assign found     = rsp_tdata[STATUS_W];
   assign count     = rsp_tdata[STATUS_W+1 +: CNT_W];
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_full  = rsp_tvalid && (status == STATUS_FULL);
   assign rsp_empty = rsp_tvalid && (status == STATUS_EMPTY);

   // A stalled response keeps its contents.
   `BDQS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   `BDQS_ASSERT_IMP(a_count_bound, clock, reset, rsp_tvalid, count <= CNT_W'(DEPTH))

   `BDQS_ASSERT_IMP(a_found_ok, clock, reset, rsp_tvalid && found, status == STATUS_OK)

   // A refused push leaves a full store; an empty report leaves an empty one.
   `BDQS_ASSERT_IMP(a_full_count, clock, reset, rsp_full, count == CNT_W'(DEPTH))

   `BDQS_ASSERT_IMP(a_empty_count, clock, reset, rsp_empty, count == '0)

endmodule

bind bounded_deque_with_search bdqs_checker #(.DEPTH(DEPTH)) u_bdqs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/bounded_deque_with_search_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the deque, keeps its own copy of the stored values and
// compares every response transfer with the outcome predicted for its request.
module bounded_deque_with_search_checker #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   // From bit 0 up: action (3 bits), value (32 bits, signed), zero padding.
   input  logic [39:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   // From bit 0 up: status (2 bits), found (1 bit), element_count (5 bits).
   input  logic [7:0] rsp_tdata,
   output int         mismatch_count,
   output int         pending_count,
   output int         find_hits,
   output int         full_refusals,
   output int         empty_reports
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      bdqs_pkg::status_type status;
      logic                 found;
      logic [CNT_W-1:0]     count;
   } outcome_type;

   logic [31:0]      slots [DEPTH];
   logic [IDX_W-1:0] front_pos = '0;
   logic [CNT_W-1:0] stored = '0;
   outcome_type      outcome_q [$];
   int               errs = 0;
   int               hits = 0;
   int               refusals = 0;
   int               empties = 0;

   // Applies one action to the shadow deque and returns the response it should give.
   function automatic outcome_type deque_apply(input logic [2:0] act, input logic [31:0] key);
      outcome_type      res;
      logic [IDX_W-1:0] pos;
      res.status = bdqs_pkg::STATUS_OK;
      res.found  = 1'b0;
      case (act)
         bdqs_pkg::ACT_PUSH_HEAD, bdqs_pkg::ACT_PUSH_TAIL: begin
            if (stored == CNT_W'(DEPTH)) begin
               res.status = bdqs_pkg::STATUS_FULL;
            end else if (act == bdqs_pkg::ACT_PUSH_HEAD) begin
               front_pos = front_pos - 1'b1;
               slots[front_pos] = key;
               stored = stored + 1'b1;
            end else begin
               pos = front_pos + IDX_W'(stored);
               slots[pos] = key;
               stored = stored + 1'b1;
            end
         end
         bdqs_pkg::ACT_POP_HEAD, bdqs_pkg::ACT_POP_TAIL: begin
            if (stored == '0) begin
               res.status = bdqs_pkg::STATUS_EMPTY;
            end else begin
               if (act == bdqs_pkg::ACT_POP_HEAD) front_pos = front_pos + 1'b1;
               stored = stored - 1'b1;
            end
         end
         bdqs_pkg::ACT_FIND: begin
            if (stored == '0) begin
               res.status = bdqs_pkg::STATUS_EMPTY;
            end else begin
               for (int i = 0; i < int'(stored); i++) begin
                  pos = front_pos + IDX_W'(i);
                  if (slots[pos] == key) res.found = 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.count = stored;
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         // The request is taken before the response is checked.
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(deque_apply(req_tdata[2:0], req_tdata[34:3]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               if (errs < 10)
                  $display("mismatch at %0t: response 0x%02h with no request waiting",
                           $time, rsp_tdata);
               errs++;
            end else begin
               want = outcome_q.pop_front();
               if (want.found) hits++;
               if (want.status == bdqs_pkg::STATUS_FULL) refusals++;
               if (want.status == bdqs_pkg::STATUS_EMPTY) empties++;
               if (rsp_tdata[1:0] !== want.status || rsp_tdata[2] !== want.found ||
                   rsp_tdata[3 +: CNT_W] !== want.count) begin
                  if (errs < 10)
                     $display("mismatch at %0t: want status %0d found %0b count %0d, got %0d %0b %0d",
                              $time, want.status, want.found, want.count,
                              rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[3 +: CNT_W]);
                  errs++;
               end
            end
         end
      end
      mismatch_count <= errs;
      pending_count  <= outcome_q.size();
      find_hits      <= hits;
      full_refusals  <= refusals;
      empty_reports  <= empties;
   end

endmodule

[tb/tb_bounded_deque_with_search.sv]
`timescale 1ns / 1ps

// Top of the deque testbench. It produces the request stream and the response
// back-pressure; all prediction and comparison is left to the checker beside the block.
module tb_bounded_deque_with_search;

   // Codes 5 to 7 are not actions; the block must answer them without changing anything.
   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

   // A find walks at most sixteen entries, so DRAIN_CYCLES covers any tail of work.
   localparam int DRAIN_CYCLES = 60;
   // Cycles without any transfer on either side before the run is declared hung.
   localparam int QUIET_LIMIT  = 4000;
   // Requests per pacing phase, not counting unused action codes.
   localparam int PHASE_ITEMS  = 215;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // From bit 0 up: action (3 bits), value (32 bits, signed), zero padding.
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // From bit 0 up: status (2 bits), found (1 bit), element_count (5 bits).
   logic [7:0]  rsp_tdata;

   int mismatch_count;
   int pending_count;
   int find_hits;
   int full_refusals;
   int empty_reports;

   // Pacing of both sides; changed from phase to phase by the stimulus process.
   int idle_pct = 0;
   int stall_pct = 0;
   int idle_by_phase [4] = '{0, 77, 0, 18};
   int stall_by_phase [4] = '{0, 0, 77, 18};

   // Requests with a real action that have been accepted, and the values pushed recently,
   // which serve as search keys that are likely to be present.
   int          real_requests = 0;
   logic [31:0] recent_values [$];

   bounded_deque_with_search u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bounded_deque_with_search_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .find_hits      (find_hits),
      .full_refusals  (full_refusals),
      .empty_reports  (empty_reports)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver decides afresh on every cycle whether it will take a response.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Values lean towards the extremes and a small set of repeats, so that searches
   // meet duplicates and sign-boundary patterns as well as arbitrary words.
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 4)  return 32'h8000_0000;
      if (r < 8)  return 32'h7fff_ffff;
      if (r < 12) return 32'hffff_ffff;
      if (r < 16) return 32'h0000_0000;
      if (r < 40) return 32'($urandom_range(7));
      return $urandom;
   endfunction

   // Half of the search keys are taken from values pushed a short while ago.
   function automatic logic [31:0] pick_key();
      if (recent_values.size() != 0 && $urandom_range(1) == 1)
         return recent_values[$urandom_range(recent_values.size() - 1)];
      return pick_value();
   endfunction

   // Chooses an action according to the mix of the current run: filling runs drive the
   // store to full, draining runs empty it, balanced runs wander in between.
   function automatic logic [2:0] pick_action(input mix_type mix);
      int r;
      int push_top;
      int find_top;
      r = $urandom_range(99);
      case (mix)
         MIX_FILL:  begin push_top = 65; find_top = 85; end
         MIX_DRAIN: begin push_top = 15; find_top = 35; end
         default:   begin push_top = 40; find_top = 65; end
      endcase
      if (r < 4) return 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      if (r < push_top)
         return ($urandom_range(1) == 1) ? bdqs_pkg::ACT_PUSH_HEAD : bdqs_pkg::ACT_PUSH_TAIL;
      if (r < find_top) return bdqs_pkg::ACT_FIND;
      return ($urandom_range(1) == 1) ? bdqs_pkg::ACT_POP_HEAD : bdqs_pkg::ACT_POP_TAIL;
   endfunction

   // Offers one request and returns at the edge where it is accepted. A gap, when the
   // pacing asks for one, is inserted before the request is put on the bus, so tvalid
   // is only ever lowered in the cycle straight after a transfer.
   task automatic send_request(input logic [2:0] act, input logic [31:0] val);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, val, act};
      do @(posedge clock); while (!req_tready);
      if (act <= bdqs_pkg::ACT_FIND) real_requests++;
      if (act == bdqs_pkg::ACT_PUSH_HEAD || act == bdqs_pkg::ACT_PUSH_TAIL) begin
         recent_values.push_back(val);
         if (recent_values.size() > 24) void'(recent_values.pop_front());
      end
   endtask

   // Stimulus and verdict.
   initial begin
      int          target;
      int          run_len;
      mix_type     mix;
      logic [2:0]  act;
      int          failures;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: every action but a head push on an empty store, the two extreme
      // values pushed from opposite ends and searched for, a search that misses, the unused
      // codes, and finally pops that take the store back to empty through its last value.
      send_request(bdqs_pkg::ACT_FIND,      32'h0000_0000);
      send_request(bdqs_pkg::ACT_POP_HEAD,  32'hffff_ffff);
      send_request(bdqs_pkg::ACT_POP_TAIL,  32'h0000_0000);
      send_request(bdqs_pkg::ACT_PUSH_TAIL, 32'h7fff_ffff);
      send_request(bdqs_pkg::ACT_PUSH_HEAD, 32'h8000_0000);
      send_request(bdqs_pkg::ACT_FIND,      32'h8000_0000);
      send_request(bdqs_pkg::ACT_FIND,      32'h7fff_ffff);
      send_request(bdqs_pkg::ACT_FIND,      32'hffff_ffff);
      send_request(ACT_UNUSED_LO,           32'h1234_5678);
      send_request(ACT_UNUSED_LO + 3'd1,    32'hffff_ffff);
      send_request(ACT_UNUSED_HI,           32'h0000_0000);
      send_request(bdqs_pkg::ACT_POP_TAIL,  32'h0000_0000);
      send_request(bdqs_pkg::ACT_POP_HEAD,  32'h0000_0000);
      send_request(bdqs_pkg::ACT_FIND,      32'h8000_0000);

      // Random part in four pacing phases. Each phase is made of short runs with a
      // filling, draining or balanced mix, so the store keeps crossing full and empty.
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         target    = real_requests + PHASE_ITEMS;
         while (real_requests < target) begin
            mix     = mix_type'($urandom_range(2));
            run_len = $urandom_range(40, 8);
            repeat (run_len) begin
               act = pick_action(mix);
               send_request(act, (act == bdqs_pkg::ACT_FIND) ? pick_key() : pick_value());
            end
         end
      end
      req_tvalid <= 1'b0;

      // The checker's count is registered and lags the transfers, which is allowed for before
      // waiting for it to reach zero. The watchdog guards this wait.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      failures = mismatch_count + pending_count;
      $display("summary: %0d requests over four pacing phases, %0d searches matched,",
               real_requests, find_hits);
      $display("summary: %0d pushes refused on a full store, %0d actions met an empty one",
               full_refusals, empty_reports);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Ends the run if neither channel completes a transfer for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
